@@ rtl/core/ohm_pkg.sv @@
// Shared types, constants and register codes for the ohmmeter range and average block.
package ohm_pkg;

    // Samples per averaged reading
    localparam int SAMPLES_PER_READING = 100;

    localparam int FS_W      = 12;
    localparam int COEF_W    = 10;
    localparam int BYTE_W    = 8;
    localparam int ADC_W     = 12;
    localparam int RANGE_W   = 2;
    localparam int READING_W = 20;
    localparam int SUM_W     = 19;
    localparam int CNT_W     = 7;
    localparam int NUM_RANGE = 4;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_R0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_R1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_R2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_R3 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_COEF_R0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_COEF_R1 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_COEF_R2 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_COEF_R3 = 4'd7;

    localparam logic [FS_W-1:0] FS_RESET_R0 = 12'd3959;
    localparam logic [FS_W-1:0] FS_RESET_R1 = 12'd3988;
    localparam logic [FS_W-1:0] FS_RESET_R2 = 12'd3997;
    localparam logic [FS_W-1:0] FS_RESET_R3 = 12'd3990;

    localparam logic [COEF_W-1:0] COEF_RESET_R0 = 10'd200;
    localparam logic [COEF_W-1:0] COEF_RESET_R1 = 10'd2;
    localparam logic [COEF_W-1:0] COEF_RESET_R2 = 10'd20;
    localparam logic [COEF_W-1:0] COEF_RESET_R3 = 10'd100;

    // Display link frame codes
    localparam logic [BYTE_W-1:0] FRAME_END_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] BTN_RANGE_DOWN = 8'h04;
    localparam logic [BYTE_W-1:0] BTN_RANGE_UP   = 8'h03;
    localparam logic [RANGE_W-1:0] RANGE_MAX     = 2'd3;

    // Result kinds
    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_READING = 1'b1;

    typedef enum logic [2:0] {
        C_IDLE,
        C_FN,
        C_LIM,
        C_S200,
        C_SK,
        C_NUM,
        C_ADD,
        C_DIV
    } calc_state_t;

    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   sum;
        logic [FS_W-1:0]    fs;
        logic [COEF_W-1:0]  coef;
    } calc_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [READING_W-1:0] reading;
        logic                 over;
    } calc_rsp_t;

    typedef struct packed {
        logic               report;
        logic [RANGE_W-1:0] range_next;
        logic [RANGE_W-1:0] range_cur;
    } frame_rsp_t;

    typedef struct packed {
        logic                 kind;
        logic [RANGE_W-1:0]   range_now;
        logic                 unit_kilo;
        logic [READING_W-1:0] reading_milli;
        logic                 over_range;
    } result_t;

endpackage

@@ rtl/core/ohm_if.sv @@
// Valid/ready channel interfaces: input item, result item and configuration write.
interface ohm_item_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [ohm_pkg::BYTE_W-1:0]    link_byte;
    logic [ohm_pkg::ADC_W-1:0]     adc_sample;

    modport source (output valid, cmd, link_byte, adc_sample, input ready);
    modport sink   (input valid, cmd, link_byte, adc_sample, output ready);
endinterface

interface ohm_result_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [ohm_pkg::RANGE_W-1:0]    range_now;
    logic                           unit_kilo;
    logic [ohm_pkg::READING_W-1:0]  reading_milli;
    logic                           over_range;

    modport source (output valid, kind, range_now, unit_kilo, reading_milli, over_range,
                    input ready);
    modport sink   (input valid, kind, range_now, unit_kilo, reading_milli, over_range,
                    output ready);
endinterface

interface ohm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ohm_pkg::CFG_IDX_W-1:0]   index;
    logic [ohm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/ohm_frame.sv @@
// Display byte history, frame end detection and range selection.
module ohm_frame (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  logic [ohm_pkg::BYTE_W-1:0]     link_byte,
    output ohm_pkg::frame_rsp_t            rsp
);

    logic [ohm_pkg::BYTE_W-1:0]  hist_reg  [4];
    logic [ohm_pkg::BYTE_W-1:0]  hist_next [4];
    logic [ohm_pkg::RANGE_W-1:0] range_reg;
    logic [ohm_pkg::RANGE_W-1:0] range_next;
    logic                        frame_end;

    always_comb
    begin
        frame_end = (link_byte == ohm_pkg::FRAME_END_BYTE)
                 && (hist_reg[0] == ohm_pkg::FRAME_END_BYTE)
                 && (hist_reg[1] == ohm_pkg::FRAME_END_BYTE);
        range_next = range_reg;
        hist_next  = hist_reg;
        if (take)
        begin
            if (frame_end)
            begin
                // ID sits four bytes back; other IDs leave the range alone
                if (hist_reg[3] == ohm_pkg::BTN_RANGE_DOWN)
                begin
                    if (range_reg != '0)
                        range_next = range_reg - 1'b1;
                end
                else if (hist_reg[3] == ohm_pkg::BTN_RANGE_UP)
                begin
                    if (range_reg != ohm_pkg::RANGE_MAX)
                        range_next = range_reg + 1'b1;
                end
                for (int i = 0; i < 4; i++)
                    hist_next[i] = '0;
            end
            else
            begin
                hist_next[3] = hist_reg[2];
                hist_next[2] = hist_reg[1];
                hist_next[1] = hist_reg[0];
                hist_next[0] = link_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= '0;
            for (int i = 0; i < 4; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            range_reg <= range_next;
            hist_reg  <= hist_next;
        end
    end

    assign rsp.report     = take && frame_end;
    assign rsp.range_next = range_next;
    assign rsp.range_cur  = range_reg;

endmodule

@@ rtl/core/ohm_calc.sv @@
// Reading calculation: one shared multiplier and a restoring divider under a sequencer.
module ohm_calc (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ohm_pkg::calc_req_t   req,
    output ohm_pkg::calc_rsp_t   rsp
);

    localparam int MUL_A_W   = 29;
    localparam int MUL_B_W   = 11;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int FN_W      = 19;
    localparam int LIM_W     = 27;
    localparam int DEN_W     = FN_W + 1;
    localparam int QUO_W     = ohm_pkg::READING_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int HI_W      = ACC_W - QUO_W;
    localparam int STEP_W    = $clog2(QUO_W);

    localparam logic [MUL_B_W-1:0] MUL_N     = MUL_B_W'(ohm_pkg::SAMPLES_PER_READING);
    localparam logic [MUL_B_W-1:0] MUL_LIM   = 11'd201;
    localparam logic [MUL_B_W-1:0] MUL_S     = 11'd200;
    localparam logic [MUL_B_W-1:0] MUL_SCALE = 11'd2000;
    localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(QUO_W - 1);

    ohm_pkg::calc_state_t state_reg, state_next;

    logic [ohm_pkg::SUM_W-1:0]   sum_reg;
    logic [ohm_pkg::FS_W-1:0]    fs_reg;
    logic [ohm_pkg::COEF_W-1:0]  coef_reg;
    logic [FN_W-1:0]             fn_reg;
    logic [LIM_W-1:0]            lim_reg;
    logic [MUL_A_W-1:0]          sk_reg;
    logic [PROD_W-1:0]           num_reg;
    logic [ACC_W-1:0]            acc_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [QUO_W-1:0]            reading_reg;
    logic                        over_reg;
    logic                        done_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic               over_hit;

    // divider step
    logic [ACC_W-1:0]   acc_sh;
    logic [HI_W:0]      diff;
    logic [ACC_W-1:0]   acc_step;
    logic [DEN_W-1:0]   den;

    assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign over_hit = prod[LIM_W-1:0] > lim_reg;
    assign den      = {fn_reg, 1'b0};

    always_comb
    begin
        acc_sh   = {acc_reg[ACC_W-2:0], 1'b0};
        diff     = {1'b0, acc_sh[ACC_W-1:QUO_W]} - (HI_W+1)'(den);
        acc_step = diff[HI_W] ? acc_sh : {diff[HI_W-1:0], acc_sh[QUO_W-1:1], 1'b1};
    end

    always_comb
    begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            ohm_pkg::C_IDLE:
            begin
                if (req.start)
                    state_next = ohm_pkg::C_FN;
            end
            ohm_pkg::C_FN:
            begin
                mul_a      = MUL_A_W'(fs_reg);
                mul_b      = MUL_N;
                state_next = ohm_pkg::C_LIM;
            end
            ohm_pkg::C_LIM:
            begin
                mul_a      = MUL_A_W'(fn_reg);
                mul_b      = MUL_LIM;
                state_next = ohm_pkg::C_S200;
            end
            ohm_pkg::C_S200:
            begin
                mul_a      = MUL_A_W'(sum_reg);
                mul_b      = MUL_S;
                state_next = over_hit ? ohm_pkg::C_IDLE : ohm_pkg::C_SK;
            end
            ohm_pkg::C_SK:
            begin
                mul_a      = MUL_A_W'(sum_reg);
                mul_b      = MUL_B_W'(coef_reg);
                state_next = ohm_pkg::C_NUM;
            end
            ohm_pkg::C_NUM:
            begin
                mul_a      = sk_reg;
                mul_b      = MUL_SCALE;
                state_next = ohm_pkg::C_ADD;
            end
            ohm_pkg::C_ADD:
                state_next = ohm_pkg::C_DIV;
            ohm_pkg::C_DIV:
            begin
                if (step_reg == LAST_STEP)
                    state_next = ohm_pkg::C_IDLE;
            end
            default:
                state_next = ohm_pkg::C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ohm_pkg::C_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == ohm_pkg::C_S200) && over_hit)
                      || ((state_reg == ohm_pkg::C_DIV) && (step_reg == LAST_STEP));
            if (state_reg == ohm_pkg::C_DIV)
                step_reg <= step_reg + 1'b1;
            else
                step_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ohm_pkg::C_IDLE:
            begin
                if (req.start)
                begin
                    sum_reg  <= req.sum;
                    // zero full scale counts as one
                    fs_reg   <= (req.fs == '0) ? ohm_pkg::FS_W'(1) : req.fs;
                    coef_reg <= req.coef;
                end
            end
            ohm_pkg::C_FN:   fn_reg  <= prod[FN_W-1:0];
            ohm_pkg::C_LIM:  lim_reg <= prod[LIM_W-1:0];
            ohm_pkg::C_S200:
            begin
                over_reg <= over_hit;
                if (over_hit)
                    reading_reg <= '0;
            end
            ohm_pkg::C_SK:   sk_reg  <= prod[MUL_A_W-1:0];
            ohm_pkg::C_NUM:  num_reg <= prod;
            ohm_pkg::C_ADD:  acc_reg <= {1'b0, num_reg + PROD_W'(fn_reg)};
            ohm_pkg::C_DIV:
            begin
                acc_reg <= acc_step;
                if (step_reg == LAST_STEP)
                    reading_reg <= acc_step[QUO_W-1:0];
            end
            default: ;
        endcase
    end

    assign rsp.busy    = (state_reg != ohm_pkg::C_IDLE) || done_reg;
    assign rsp.done    = done_reg;
    assign rsp.reading = reading_reg;
    assign rsp.over    = over_reg;

endmodule

@@ rtl/core/ohmmeter_range_and_average.sv @@
// Top level of the ohmmeter range selection and averaged reading block.
// Channels:
//   item   - input items: cmd 0 carries a display link byte, cmd 1 an ADC sample.
//   result - kind 0 is a range report after a display frame, kind 1 a finished,
//            calibrated reading with its over-range flag.
//   cfg    - register writes (index 0..3 full scale, 4..7 range coefficient),
//            always ready; indexes above 7 are dropped.
// Flow:
//   Bytes and samples are taken one per cycle while item.ready is high; a frame
//   report is registered into the output queue as its last byte is accepted.
//   A completing sample runs five product steps on the shared multiplier, one
//   add step, then 20 divider steps (stopping early at the over-range check),
//   with item.ready low; the reading is visible in the cycle item.ready returns.
// Stalls:
//   Results go through a two-entry output queue, so items keep being taken while
//   one result waits; item.ready drops while the calculator is busy, and when the
//   second entry is filled, until result.ready drains it.
// Reset:
//   rst_n clears the byte history, range (to 0), batch count and sum, and the
//   queue, and loads the calibrated register defaults.
module ohmmeter_range_and_average (
    input  logic            clk,
    input  logic            rst_n,
    ohm_item_if.sink        item,
    ohm_result_if.source    result,
    ohm_cfg_if.sink         cfg
);

    // calibration registers
    logic [ohm_pkg::FS_W-1:0]   fs_reg   [ohm_pkg::NUM_RANGE];
    logic [ohm_pkg::COEF_W-1:0] coef_reg [ohm_pkg::NUM_RANGE];

    // batch accumulation
    logic [ohm_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [ohm_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ohm_pkg::SUM_W-1:0]  sum_add;
    logic [ohm_pkg::CNT_W-1:0]  cnt_inc;

    logic [ohm_pkg::RANGE_W-1:0] calc_range_reg;

    // output queue: head register plus one skid entry
    ohm_pkg::result_t out_reg, out_next;
    ohm_pkg::result_t skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;

    logic             accept;
    logic             byte_take;
    logic             sample_take;
    logic             batch_end;
    logic             push;
    ohm_pkg::result_t push_data;

    ohm_pkg::frame_rsp_t frame_rsp;
    ohm_pkg::calc_req_t  calc_req;
    ohm_pkg::calc_rsp_t  calc_rsp;

    // ---------------- input side ----------------
    assign item.ready  = !calc_rsp.busy && !skid_valid_reg;
    assign accept      = item.valid && item.ready;
    assign byte_take   = accept && !item.cmd;
    assign sample_take = accept && item.cmd;

    assign sum_add   = sum_reg + ohm_pkg::SUM_W'(item.adc_sample);
    assign cnt_inc   = cnt_reg + 1'b1;
    assign batch_end = sample_take
                    && (cnt_inc >= ohm_pkg::CNT_W'(ohm_pkg::SAMPLES_PER_READING));

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (sample_take)
        begin
            // batch restarts once its sum is handed to the calculator
            sum_next = batch_end ? '0 : sum_add;
            cnt_next = batch_end ? '0 : cnt_inc;
        end
    end

    ohm_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (byte_take),
        .link_byte (item.link_byte),
        .rsp       (frame_rsp)
    );

    // range in force when the batch completes selects the calibration
    assign calc_req.start = batch_end;
    assign calc_req.sum   = sum_add;
    assign calc_req.fs    = fs_reg[frame_rsp.range_cur];
    assign calc_req.coef  = coef_reg[frame_rsp.range_cur];

    ohm_calc u_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (calc_req),
        .rsp   (calc_rsp)
    );

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg[0]   <= ohm_pkg::FS_RESET_R0;
            fs_reg[1]   <= ohm_pkg::FS_RESET_R1;
            fs_reg[2]   <= ohm_pkg::FS_RESET_R2;
            fs_reg[3]   <= ohm_pkg::FS_RESET_R3;
            coef_reg[0] <= ohm_pkg::COEF_RESET_R0;
            coef_reg[1] <= ohm_pkg::COEF_RESET_R1;
            coef_reg[2] <= ohm_pkg::COEF_RESET_R2;
            coef_reg[3] <= ohm_pkg::COEF_RESET_R3;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                ohm_pkg::REG_FULL_SCALE_R0: fs_reg[0]   <= cfg.data;
                ohm_pkg::REG_FULL_SCALE_R1: fs_reg[1]   <= cfg.data;
                ohm_pkg::REG_FULL_SCALE_R2: fs_reg[2]   <= cfg.data;
                ohm_pkg::REG_FULL_SCALE_R3: fs_reg[3]   <= cfg.data;
                ohm_pkg::REG_RANGE_COEF_R0: coef_reg[0] <= cfg.data[ohm_pkg::COEF_W-1:0];
                ohm_pkg::REG_RANGE_COEF_R1: coef_reg[1] <= cfg.data[ohm_pkg::COEF_W-1:0];
                ohm_pkg::REG_RANGE_COEF_R2: coef_reg[2] <= cfg.data[ohm_pkg::COEF_W-1:0];
                ohm_pkg::REG_RANGE_COEF_R3: coef_reg[3] <= cfg.data[ohm_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- result assembly ----------------
    // A frame report and a finished reading never land in the same cycle:
    // no item is taken while the calculator is busy.
    always_comb
    begin
        push_data = '0;
        push      = 1'b0;
        if (calc_rsp.done)
        begin
            push                    = 1'b1;
            push_data.kind          = ohm_pkg::KIND_READING;
            push_data.range_now     = calc_range_reg;
            push_data.unit_kilo     = (calc_range_reg != '0);
            push_data.reading_milli = calc_rsp.reading;
            push_data.over_range    = calc_rsp.over;
        end
        else if (frame_rsp.report)
        begin
            push                = 1'b1;
            push_data.kind      = ohm_pkg::KIND_REPORT;
            push_data.range_now = frame_rsp.range_next;
            push_data.unit_kilo = (frame_rsp.range_next != '0);
        end
    end

    // skid entry fills only when the head is held; no push while it is full
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
                out_next = push_data;
            else
                out_valid_next = 1'b0;
        end
        else if (out_valid_reg)
        begin
            if (push)
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (push)
        begin
            out_next       = push_data;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg        <= sum_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
        if (batch_end)
            calc_range_reg <= frame_rsp.range_cur;
    end

    assign result.valid         = out_valid_reg;
    assign result.kind          = out_reg.kind;
    assign result.range_now     = out_reg.range_now;
    assign result.unit_kilo     = out_reg.unit_kilo;
    assign result.reading_milli = out_reg.reading_milli;
    assign result.over_range    = out_reg.over_range;

endmodule

@@ verif/ohmmeter_range_and_average_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the ohmmeter range selection and averaged reading block.
module ohmmeter_range_and_average_tb;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    // Longest batch finish holds the block busy; SETTLE_CYCLES leaves margin.
    localparam int SETTLE_CYCLES  = 40;
    localparam int CYCLE_LIMIT    = 50000;
    localparam int IDLE_PCT       = 37;
    localparam int NUM_PHASES     = 4;
    localparam int STEADY_PHASE   = 2;      // phase with no idling on either side
    localparam int PHASE_ITEMS    = 75;
    localparam int PHASE_READINGS = 1;
    localparam int REPORT_LIMIT   = 10;
    localparam int ADC_MAX        = (1 << ohm_pkg::ADC_W) - 1;
    localparam longint unsigned READING_MAX = (64'd1 << ohm_pkg::READING_W) - 64'd1;

    // Phases with fixed register settings: calibration extremes
    localparam int PHASE_FS_ZERO  = 1;      // full scale 0 (read as 1), coef at max
    localparam int PHASE_FS_MAX   = 2;      // full scale and coef at max

    // How the samples of one batch are drawn
    typedef enum int {
        MIX_UNIFORM,
        MIX_NEAR_FS,
        MIX_RAILS,
        MIX_SPARSE,
        MIX_FULL
    } sample_mix_e;

    // Mirror of the block: byte history, range, batch and calibration,
    // plus the queue of results still owed by the block.
    class meter_scoreboard;
        logic [ohm_pkg::BYTE_W-1:0]    hist [4];
        logic [ohm_pkg::RANGE_W-1:0]   range_sel;
        logic [ohm_pkg::CNT_W-1:0]     batch_cnt;
        logic [ohm_pkg::SUM_W-1:0]     batch_sum;
        logic [ohm_pkg::FS_W-1:0]      full_scale [ohm_pkg::NUM_RANGE];
        logic [ohm_pkg::COEF_W-1:0]    coef [ohm_pkg::NUM_RANGE];
        ohm_pkg::result_t              due_results [$];
        int                            mismatches;
        int                            readings;

        function new();
            full_scale = '{ohm_pkg::FS_RESET_R0, ohm_pkg::FS_RESET_R1,
                           ohm_pkg::FS_RESET_R2, ohm_pkg::FS_RESET_R3};
            coef       = '{ohm_pkg::COEF_RESET_R0, ohm_pkg::COEF_RESET_R1,
                           ohm_pkg::COEF_RESET_R2, ohm_pkg::COEF_RESET_R3};
            hist       = '{default: '0};
            range_sel  = '0;
            batch_cnt  = '0;
            batch_sum  = '0;
            mismatches = 0;
            readings   = 0;
        endfunction

        function void load_reg(logic [ohm_pkg::CFG_IDX_W-1:0] idx,
                               logic [ohm_pkg::CFG_DATA_W-1:0] data);
            if (idx <= ohm_pkg::REG_FULL_SCALE_R3)
                full_scale[idx - ohm_pkg::REG_FULL_SCALE_R0] = data[ohm_pkg::FS_W-1:0];
            else if (idx <= ohm_pkg::REG_RANGE_COEF_R3)
                coef[idx - ohm_pkg::REG_RANGE_COEF_R0] = data[ohm_pkg::COEF_W-1:0];
        endfunction

        function ohm_pkg::result_t outcome(logic kind, longint unsigned reading, logic over);
            ohm_pkg::result_t r;
            r.kind          = kind;
            r.range_now     = range_sel;
            r.unit_kilo     = (range_sel != '0);
            r.reading_milli = reading[ohm_pkg::READING_W-1:0];
            r.over_range    = over;
            return r;
        endfunction

        // Note one accepted item and queue the result it causes, if any.
        function void take_item(logic c, logic [ohm_pkg::BYTE_W-1:0] b,
                                logic [ohm_pkg::ADC_W-1:0] s);
            longint unsigned f, k, n, total, reading;
            logic over;
            if (c == 1'b0)
            begin
                if (b == ohm_pkg::FRAME_END_BYTE && hist[0] == ohm_pkg::FRAME_END_BYTE &&
                    hist[1] == ohm_pkg::FRAME_END_BYTE)
                begin
                    if (hist[3] == ohm_pkg::BTN_RANGE_DOWN && range_sel != '0)
                        range_sel--;
                    else if (hist[3] == ohm_pkg::BTN_RANGE_UP && range_sel != ohm_pkg::RANGE_MAX)
                        range_sel++;
                    hist = '{default: '0};
                    due_results.push_back(outcome(ohm_pkg::KIND_REPORT, 64'd0, 1'b0));
                end
                else
                begin
                    hist[3] = hist[2];
                    hist[2] = hist[1];
                    hist[1] = hist[0];
                    hist[0] = b;
                end
            end
            else
            begin
                batch_sum = batch_sum + ohm_pkg::SUM_W'(s);
                batch_cnt = batch_cnt + 1'b1;
                if (batch_cnt >= ohm_pkg::SAMPLES_PER_READING)
                begin
                    f = 64'(full_scale[range_sel]);
                    if (f == 0)
                        f = 1;
                    k     = 64'(coef[range_sel]);
                    n     = 64'(ohm_pkg::SAMPLES_PER_READING);
                    total = 64'(batch_sum);
                    over  = (200 * total > 201 * f * n);
                    if (over)
                        reading = 0;
                    else
                        reading = (2 * total * k * 1000 + f * n) / (2 * f * n);
                    if (reading > READING_MAX)
                        reading = READING_MAX;
                    batch_sum = '0;
                    batch_cnt = '0;
                    readings++;
                    due_results.push_back(outcome(ohm_pkg::KIND_READING, reading, over));
                end
            end
        endfunction

        function string show(ohm_pkg::result_t r);
            return $sformatf("kind %0d range %0d kilo %0d reading %0d over %0d",
                             r.kind, r.range_now, r.unit_kilo, r.reading_milli, r.over_range);
        endfunction

        function void match_result(ohm_pkg::result_t got);
            ohm_pkg::result_t want;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result at %0t: %s", $realtime, show(got));
                return;
            end
            want = due_results.pop_front();
            if (got.kind != want.kind || got.range_now != want.range_now ||
                got.unit_kilo != want.unit_kilo || got.reading_milli != want.reading_milli ||
                got.over_range != want.over_range)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result mismatch at %0t: expected %s, got %s",
                             $realtime, show(want), show(got));
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            steady;        // no idling on either side while set
    int              cycles;
    int              phase_items;
    sample_mix_e     mix;
    meter_scoreboard sb;

    ohm_item_if   item_ch ();
    ohm_result_if result_ch ();
    ohm_cfg_if    cfg_ch ();

    ohmmeter_range_and_average DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: a stuck handshake ends the run here.
    initial
    begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("ohmmeter_range_and_average_tb: FAIL");
        $finish;
    end

    // Result side: check on the handshake (values seen just before the edge),
    // then pick ready for the next cycle.
    initial
    begin
        ohm_pkg::result_t got;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.kind          = result_ch.kind;
                got.range_now     = result_ch.range_now;
                got.unit_kilo     = result_ch.unit_kilo;
                got.reading_milli = result_ch.reading_milli;
                got.over_range    = result_ch.over_range;
                sb.match_result(got);
            end
            result_ch.ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // One item on the input channel; valid stays high after the handshake so
    // back-to-back items need no extra assignment in the same step.
    task automatic send_item(logic c, logic [ohm_pkg::BYTE_W-1:0] b,
                             logic [ohm_pkg::ADC_W-1:0] s);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.cmd        <= c;
        item_ch.link_byte  <= b;
        item_ch.adc_sample <= s;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.take_item(c, b, s);
        phase_items++;
    endtask

    // The field that goes unused carries random bits; the block must ignore it.
    task automatic send_byte(logic [ohm_pkg::BYTE_W-1:0] b);
        send_item(1'b0, b, ohm_pkg::ADC_W'($urandom));
    endtask

    task automatic send_sample(logic [ohm_pkg::ADC_W-1:0] s);
        send_item(1'b1, ohm_pkg::BYTE_W'($urandom), s);
    endtask

    // Button ID, one filler byte, then the three-byte terminator.
    task automatic send_frame(logic [ohm_pkg::BYTE_W-1:0] id,
                              logic [ohm_pkg::BYTE_W-1:0] filler);
        send_byte(id);
        send_byte(filler);
        repeat (3) send_byte(ohm_pkg::FRAME_END_BYTE);
    endtask

    // Stop sending, wait for every owed result, then let the block settle.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [ohm_pkg::CFG_IDX_W-1:0] idx,
                             logic [ohm_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.load_reg(idx, data);
    endtask

    // Button IDs lean toward range-up so the top range saturates often.
    function automatic logic [ohm_pkg::BYTE_W-1:0] pick_id();
        case ($urandom_range(5)) inside
            0, 1, 5: return ohm_pkg::BTN_RANGE_UP;
            2, 3:    return ohm_pkg::BTN_RANGE_DOWN;
            default: return ohm_pkg::BYTE_W'($urandom);
        endcase
    endfunction

    // A new mix is drawn at each batch start. Near full scale straddles the
    // 0.5 percent over-range threshold; sparse gives tiny sums for full scale 1.
    function automatic logic [ohm_pkg::ADC_W-1:0] next_sample();
        int fs_eff;
        int hi;
        if (sb.batch_cnt == '0)
            mix = sample_mix_e'($urandom_range(MIX_FULL));
        fs_eff = (sb.full_scale[sb.range_sel] == '0) ? 1 : int'(sb.full_scale[sb.range_sel]);
        hi = fs_eff + fs_eff / 50;
        if (hi > ADC_MAX)
            hi = ADC_MAX;
        case (mix)
            MIX_UNIFORM: return ohm_pkg::ADC_W'($urandom);
            MIX_NEAR_FS: return ohm_pkg::ADC_W'($urandom_range(hi, fs_eff - fs_eff / 100));
            MIX_RAILS:   return $urandom_range(1) ? {ohm_pkg::ADC_W{1'b1}} : '0;
            MIX_SPARSE:  return ohm_pkg::ADC_W'($urandom_range(1) & $urandom_range(1));
            default:     return {ohm_pkg::ADC_W{1'b1}};
        endcase
    endfunction

    initial
    begin
        int                             start_readings;
        int                             roll;
        logic [ohm_pkg::CFG_DATA_W-1:0] fs_val;
        logic [ohm_pkg::CFG_DATA_W-1:0] coef_val;

        sb     = new();
        steady = 1'b0;
        mix    = MIX_UNIFORM;
        phase_items = 0;

        rst_n              <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.cmd        <= 1'b0;
        item_ch.link_byte  <= '0;
        item_ch.adc_sample <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening on the reset calibration.
        // Short frame: terminator with a cleared history, range stays.
        repeat (3) send_byte(ohm_pkg::FRAME_END_BYTE);
        // Range-down at range 0 saturates; then up once; then an unknown button.
        send_frame(ohm_pkg::BTN_RANGE_DOWN, 8'h00);
        send_frame(ohm_pkg::BTN_RANGE_UP, 8'h7E);
        send_frame(8'hA5, 8'h5A);
        send_sample('0);
        send_sample({ohm_pkg::ADC_W{1'b1}});

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Phase 0 runs on the reset values; later phases reprogram every
            // register with the block idle.
            if (p != 0)
            begin
                drain();
                for (int r = 0; r < ohm_pkg::NUM_RANGE; r++)
                begin
                    case (p)
                        PHASE_FS_ZERO:
                        begin
                            fs_val   = '0;
                            coef_val = {ohm_pkg::CFG_DATA_W{1'b1}};
                        end
                        PHASE_FS_MAX:
                        begin
                            fs_val   = {ohm_pkg::CFG_DATA_W{1'b1}};
                            coef_val = {ohm_pkg::CFG_DATA_W{1'b1}};
                        end
                        default:
                        begin
                            // Upper coef bits are random too: they must be dropped.
                            fs_val   = ohm_pkg::CFG_DATA_W'($urandom);
                            coef_val = ohm_pkg::CFG_DATA_W'($urandom);
                        end
                    endcase
                    write_reg(ohm_pkg::CFG_IDX_W'(ohm_pkg::REG_FULL_SCALE_R0 + r), fs_val);
                    write_reg(ohm_pkg::CFG_IDX_W'(ohm_pkg::REG_RANGE_COEF_R0 + r), coef_val);
                end
                // Index past the register file: must change nothing.
                write_reg(ohm_pkg::CFG_IDX_W'($urandom_range({ohm_pkg::CFG_IDX_W{1'b1}},
                                                             ohm_pkg::REG_RANGE_COEF_R3 + 1)),
                          ohm_pkg::CFG_DATA_W'($urandom));
                cfg_ch.valid <= 1'b0;
            end
            steady = (p == STEADY_PHASE);

            // Random traffic: mostly samples so batches complete, with frames,
            // loose bytes and partial terminators mixed in.
            phase_items    = 0;
            start_readings = sb.readings;
            while (phase_items < PHASE_ITEMS || sb.readings - start_readings < PHASE_READINGS)
            begin
                roll = $urandom_range(99);
                if (roll == 0)
                    drain();
                if (roll < 78)
                    send_sample(next_sample());
                else if (roll < 90)
                    send_frame(pick_id(), ohm_pkg::BYTE_W'($urandom));
                else if (roll < 95)
                    send_byte(ohm_pkg::BYTE_W'($urandom));
                else
                begin
                    send_byte(pick_id());
                    repeat ($urandom_range(3)) send_byte(ohm_pkg::FRAME_END_BYTE);
                end
            end
        end
        steady = 1'b0;

        drain();
        if (sb.mismatches == 0 && sb.due_results.size() == 0)
            $display("ohmmeter_range_and_average_tb: PASS");
        else
            $display("ohmmeter_range_and_average_tb: FAIL");
        $finish;
    end

endmodule
